>>> rtl/core/whfh_pkg.sv
// ----------------------------------------------------------------------------
// whfh_pkg
// Shared types and constants for the water heater fill/heat controller.
// ----------------------------------------------------------------------------
package whfh_pkg;

    localparam int unsigned MODE_W     = 3;
    localparam int unsigned TEMP_W     = 2;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned INTERVAL_W = 32;

    localparam logic [INTERVAL_W-1:0] FALLBACK_RESET = INTERVAL_W'(60000);
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE      = 3'd0,
        MODE_FILL      = 3'd1,
        MODE_HEAT      = 3'd2,
        MODE_READY     = 3'd3,
        MODE_DRAIN     = 3'd4,
        MODE_FILL_ONLY = 3'd5
    } mode_t;

    typedef enum logic [TEMP_W-1:0] {
        TEMP_OFF  = 2'd0,
        TEMP_COLD = 2'd1,
        TEMP_HOT  = 2'd2
    } temp_t;

    typedef struct packed {
        logic toggle_press;
        logic drain_press;
        logic fill_only_request;
        logic tank_full;
        logic thermostat_cold;
    } tick_in_t;

    typedef struct packed {
        mode_t mode;
        logic  fill_valve;
        logic  heater;
        logic  drain_valve;
    } ctrl_state_t;

endpackage

>>> rtl/core/water_heater_fill_heat_controller.sv
// ----------------------------------------------------------------------------
// water_heater_fill_heat_controller
// Fill/heat/drain sequencer for a water heater, one transaction per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick of debounced events and
// levels; each yields exactly one result transaction carrying the drives,
// the mode, the temperature reading and a mode-change flag. A transaction
// passes an input register, combinational next-state logic and a result
// register; a new transaction is taken every cycle while the result side
// keeps up. The fallback interval register is written through
// cfg_we/cfg_wdata and resets to 60000 ticks.
module water_heater_fill_heat_controller (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [whfh_pkg::INTERVAL_W-1:0]     cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_toggle_press,
    input  logic                                s_drain_press,
    input  logic                                s_fill_only_request,
    input  logic                                s_tank_full,
    input  logic                                s_thermostat_cold,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_fill_valve_on,
    output logic                                m_heater_on,
    output logic                                m_drain_valve_on,
    output logic [whfh_pkg::MODE_W-1:0]         m_mode,
    output logic [whfh_pkg::TEMP_W-1:0]         m_temp_reading,
    output logic                                m_mode_changed
);
    import whfh_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;

    logic        in_valid_reg;
    tick_in_t    tick_reg;

    ctrl_state_t         state_reg;
    ctrl_state_t         state_next;
    logic [COUNT_W-1:0]  ticks_reg;
    logic [COUNT_W-1:0]  ticks_next;
    temp_t               temp_next;
    logic                changed_next;

    logic        out_valid_reg;
    ctrl_state_t out_state_reg;
    temp_t       out_temp_reg;
    logic        out_changed_reg;

    logic        s_accept;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= FALLBACK_RESET;
        end else if (cfg_we) begin
            interval_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tick_reg.toggle_press      <= s_toggle_press;
            tick_reg.drain_press       <= s_drain_press;
            tick_reg.fill_only_request <= s_fill_only_request;
            tick_reg.tank_full         <= s_tank_full;
            tick_reg.thermostat_cold   <= s_thermostat_cold;
        end
    end

    whfh_step u_step (
        .tick              (tick_reg),
        .state_cur         (state_reg),
        .ticks_cur         (ticks_reg),
        .fallback_interval (interval_reg),
        .state_nxt         (state_next),
        .ticks_nxt         (ticks_next),
        .temp_reading      (temp_next),
        .mode_changed      (changed_next)
    );

    // advance controller state once per transaction moved to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_IDLE, fill_valve: 1'b0, heater: 1'b0,
                           drain_valve: 1'b0};
            ticks_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            ticks_reg <= ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg   <= state_next;
            out_temp_reg    <= temp_next;
            out_changed_reg <= changed_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_fill_valve_on  = out_state_reg.fill_valve;
    assign m_heater_on      = out_state_reg.heater;
    assign m_drain_valve_on = out_state_reg.drain_valve;
    assign m_mode           = out_state_reg.mode;
    assign m_temp_reading   = out_temp_reg;
    assign m_mode_changed   = out_changed_reg;

    a_advance_fills_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result stage empty after transfer");

    a_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(ticks_reg) && $stable(state_reg))
        else $error("controller state moved without a transaction");

    a_heater_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.heater == (state_reg.mode == MODE_HEAT ||
                             state_reg.mode == MODE_READY))
        else $error("heater drive disagrees with mode");

    a_fill_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.fill_valve == (state_reg.mode == MODE_FILL ||
                                 state_reg.mode == MODE_FILL_ONLY))
        else $error("fill valve drive disagrees with mode");

    a_change_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && changed_next |=> ticks_reg == '0)
        else $error("tick count not cleared on mode change");

endmodule

>>> rtl/core/whfh_step.sv
// ----------------------------------------------------------------------------
// whfh_step
// Next-state logic for one tick: requests, toggles, temperature read,
// refill fallback and mode transitions.
// ----------------------------------------------------------------------------
module whfh_step (
    input  whfh_pkg::tick_in_t                      tick,
    input  whfh_pkg::ctrl_state_t                   state_cur,
    input  logic [whfh_pkg::COUNT_W-1:0]            ticks_cur,
    input  logic [whfh_pkg::INTERVAL_W-1:0]         fallback_interval,
    output whfh_pkg::ctrl_state_t                   state_nxt,
    output logic [whfh_pkg::COUNT_W-1:0]            ticks_nxt,
    output whfh_pkg::temp_t                         temp_reading,
    output logic                                    mode_changed
);
    import whfh_pkg::*;

    logic [COUNT_W-1:0] count;
    ctrl_state_t        s;
    temp_t              temp;

    assign count = (ticks_cur == COUNT_MAX) ? ticks_cur : ticks_cur + COUNT_W'(1);

    always_comb begin
        s = state_cur;

        if (tick.fill_only_request && s.mode == MODE_IDLE) begin
            s.fill_valve = 1'b1;
            s.mode       = MODE_FILL_ONLY;
        end

        if (tick.toggle_press) begin
            s.heater = 1'b0;
            if (s.mode == MODE_IDLE) begin
                s.drain_valve = 1'b0;
                s.fill_valve  = 1'b1;
                s.mode        = MODE_FILL;
            end else begin
                s.fill_valve = 1'b0;
                s.mode       = MODE_IDLE;
            end
        end

        if (tick.drain_press) begin
            s.fill_valve = 1'b0;
            s.heater     = 1'b0;
            if (!s.drain_valve) begin
                s.drain_valve = 1'b1;
                s.mode        = MODE_DRAIN;
            end else begin
                s.drain_valve = 1'b0;
                s.mode        = MODE_IDLE;
            end
        end

        // sample temperature with the heater state at this point
        if (!s.heater) begin
            temp = TEMP_OFF;
        end else if (tick.thermostat_cold) begin
            temp = TEMP_COLD;
        end else begin
            temp = TEMP_HOT;
        end

        if (count >= fallback_interval && !tick.tank_full &&
            (s.mode == MODE_HEAT || s.mode == MODE_READY)) begin
            s.heater     = 1'b0;
            s.fill_valve = 1'b1;
            s.mode       = MODE_FILL;
        end

        case (s.mode)
            MODE_FILL: begin
                if (tick.tank_full) begin
                    s.fill_valve = 1'b0;
                    s.heater     = 1'b1;
                    s.mode       = MODE_HEAT;
                end
            end
            MODE_HEAT: begin
                if (temp == TEMP_HOT) begin
                    s.mode = MODE_READY;
                end
            end
            MODE_READY: begin
                if (temp == TEMP_COLD) begin
                    s.mode = MODE_HEAT;
                end
            end
            MODE_FILL_ONLY: begin
                if (tick.tank_full) begin
                    s.fill_valve = 1'b0;
                    s.mode       = MODE_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    assign state_nxt    = s;
    assign temp_reading = temp;
    assign mode_changed = (s.mode != state_cur.mode);
    assign ticks_nxt    = mode_changed ? '0 : count;

endmodule
